[hdl/leg_forward_kinematics_jacobian_unit_macros.svh]
// Assertion macros for the leg kinematics unit checker.
// Included by the checker file only.
`ifndef LEG_FORWARD_KINEMATICS_JACOBIAN_UNIT_MACROS_SVH
`define LEG_FORWARD_KINEMATICS_JACOBIAN_UNIT_MACROS_SVH
`define LFKJ_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("lfkj check failed");
`define LFKJ_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("lfkj check failed");
`endif

[hdl/lfkj_pkg.sv]
// Shared types and constants for the leg kinematics unit.
// No dependencies.
package lfkj_pkg;
  localparam int QW = 36;
  localparam logic signed [QW-1:0] TURN = 36'sd1686629713;
  localparam logic signed [QW-1:0] HALF = 36'sd843314857;
  localparam logic signed [QW-1:0] QUARTER = 36'sd421657428;
  localparam logic signed [QW-1:0] GAIN = 36'sd163008218;
  localparam int NSTEP = 17;
  localparam int NRES = 20;

  localparam logic [2:0] REG_THIGH = 3'd0;
  localparam logic [2:0] REG_SHANK = 3'd1;
  localparam logic [2:0] REG_REACH = 3'd2;
  localparam logic [2:0] REG_FORE = 3'd3;
  localparam logic [2:0] REG_SIDE = 3'd4;
  localparam logic [2:0] REG_DOWN = 3'd5;

  typedef struct packed {
    logic cordic_start;
    logic [2:0] cordic_sel;
    logic [4:0] emit_index;
    logic emit_load;
  } lfkj_cmd_t;

  typedef struct packed {
    logic cordic_done;
  } lfkj_status_t;

  function automatic logic signed [QW-1:0] atan_entry(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0: v = 17'd51472; 5'd1: v = 17'd30386; 5'd2: v = 17'd16055;
      5'd3: v = 17'd8150; 5'd4: v = 17'd4091; 5'd5: v = 17'd2047;
      5'd6: v = 17'd1024; 5'd7: v = 17'd512; 5'd8: v = 17'd256;
      5'd9: v = 17'd128; 5'd10: v = 17'd64; 5'd11: v = 17'd32;
      5'd12: v = 17'd16; 5'd13: v = 17'd8; 5'd14: v = 17'd4;
      5'd15: v = 17'd2; 5'd16: v = 17'd1;
      default: v = 17'd0;
    endcase
    return $signed({7'd0, v, 12'd0});
  endfunction
endpackage

[hdl/lfkj_ctrl.sv]
// Sequencer for the leg kinematics unit: six sine/cosine runs, then twenty results.
// Depends on lfkj_pkg.
module lfkj_ctrl import lfkj_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic out_free,
  input  lfkj_status_t status,
  output lfkj_cmd_t cmd,
  output logic busy
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TRIG = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state, state_next;
  logic [2:0] sel, sel_next;
  logic [4:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel <= '0;
      idx <= '0;
    end else begin
      state <= state_next;
      sel <= sel_next;
      idx <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next = sel;
    idx_next = idx;
    cmd = '0;
    cmd.cordic_sel = sel;
    cmd.emit_index = idx;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          sel_next = '0;
          state_next = S_TRIG;
        end
      end
      S_TRIG: begin
        cmd.cordic_start = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (status.cordic_done) begin
          if (sel == 3'd5) begin
            idx_next = '0;
            state_next = S_EMIT;
          end else begin
            sel_next = sel + 3'd1;
            state_next = S_TRIG;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit_load = 1'b1;
          if (idx == 5'(NRES - 1)) state_next = S_IDLE;
          else idx_next = idx + 5'd1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule

[hdl/lfkj_datapath.sv]
// Datapath for the leg kinematics unit: angle latch, shared CORDIC, product unit.
// Depends on lfkj_pkg.
module lfkj_datapath import lfkj_pkg::*; #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic latch,
  input  logic signed [ANGLE_WIDTH-1:0] ang_in [6],
  input  logic [13:0] thigh, shank, reach, fore, side, down,
  input  lfkj_cmd_t cmd,
  output lfkj_status_t status,
  output logic [2:0] r_row,
  output logic [2:0] r_col,
  output logic r_kind,
  output logic signed [15:0] r_value
);
  logic signed [ANGLE_WIDTH-1:0] ang [6];
  logic signed [QW-1:0] cx, cy, cz;
  logic [4:0] step;
  logic run, flip;
  logic signed [15:0] sn [6];
  logic signed [15:0] cs [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) ang[i] <= '0;
    end else if (latch) begin
      for (int i = 0; i < 6; i++) ang[i] <= ang_in[i];
    end
  end

  // Angle selected for the current run: per leg abduct, flex, flex minus knee.
  logic signed [QW-1:0] a_sel, a_w, a_f;
  logic f_sel;
  always_comb begin
    unique case (cmd.cordic_sel)
      3'd0: a_sel = QW'(ang[2]) <<< (28 - (ANGLE_WIDTH - 4));
      3'd1: a_sel = QW'(ang[0]) <<< (28 - (ANGLE_WIDTH - 4));
      3'd2: a_sel = (QW'(ang[0]) - QW'(ang[1])) <<< (28 - (ANGLE_WIDTH - 4));
      3'd3: a_sel = QW'(ang[5]) <<< (28 - (ANGLE_WIDTH - 4));
      3'd4: a_sel = QW'(ang[3]) <<< (28 - (ANGLE_WIDTH - 4));
      default: a_sel = (QW'(ang[3]) - QW'(ang[4])) <<< (28 - (ANGLE_WIDTH - 4));
    endcase
    a_w = a_sel;
    if (a_w >= HALF) a_w = a_w - TURN;
    if (a_w >= HALF) a_w = a_w - TURN;
    if (a_w >= HALF) a_w = a_w - TURN;
    if (a_w < -HALF) a_w = a_w + TURN;
    if (a_w < -HALF) a_w = a_w + TURN;
    if (a_w < -HALF) a_w = a_w + TURN;
    f_sel = 1'b0;
    a_f = a_w;
    if (a_w > QUARTER) begin
      a_f = HALF - a_w;
      f_sel = 1'b1;
    end else if (a_w < -QUARTER) begin
      a_f = -HALF - a_w;
      f_sel = 1'b1;
    end
  end

  logic signed [QW-1:0] ys_rnd, xs_rnd, s_c, c_c;
  always_comb begin
    ys_rnd = (cy + QW'(8192)) >>> 14;
    xs_rnd = (cx + QW'(8192)) >>> 14;
    s_c = (ys_rnd > 36'sd16384) ? 36'sd16384 : ((ys_rnd < -36'sd16384) ? -36'sd16384 : ys_rnd);
    c_c = (xs_rnd > 36'sd16384) ? 36'sd16384 : ((xs_rnd < -36'sd16384) ? -36'sd16384 : xs_rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      step <= '0;
    end else if (cmd.cordic_start) begin
      run <= 1'b1;
      step <= '0;
    end else if (run) begin
      if (step == 5'(NSTEP - 1)) run <= 1'b0;
      step <= step + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cordic_start) begin
      cx <= GAIN;
      cy <= '0;
      cz <= a_f;
      flip <= f_sel;
    end else if (run) begin
      if (cz >= 0) begin
        cx <= cx - (cy >>> step);
        cy <= cy + (cx >>> step);
        cz <= cz - atan_entry(step);
      end else begin
        cx <= cx + (cy >>> step);
        cy <= cy - (cx >>> step);
        cz <= cz + atan_entry(step);
      end
    end
  end

  logic done_q;
  always_ff @(posedge clk) begin
    if (rst) done_q <= 1'b0;
    else done_q <= run && (step == 5'(NSTEP - 1));
  end
  assign status.cordic_done = done_q;

  always_ff @(posedge clk) begin
    if (done_q) begin
      sn[cmd.cordic_sel] <= s_c[15:0];
      cs[cmd.cordic_sel] <= flip ? -c_c[15:0] : c_c[15:0];
    end
  end

  // Result selection: per result one product sum in Q28, then rounding.
  logic lg;
  logic [2:0] base;
  logic signed [15:0] sa, ca, sh, ch, sd, cd;
  logic signed [31:0] p1a, p1b, p2a, p2b;
  logic signed [31:0] m1, m2;
  logic signed [14:0] k1, k2;
  logic signed [63:0] acc, off;
  logic [2:0] row, col;
  logic kind;
  always_comb begin
    lg = 1'b0;
    row = '0;
    col = '0;
    kind = 1'b0;
    p1a = '0; p1b = '0; p2a = '0; p2b = '0;
    k1 = '0; k2 = '0;
    off = '0;
    if (cmd.emit_index < 5'd6) begin
      lg = (cmd.emit_index >= 5'd3);
      row = cmd.emit_index[2:0];
    end else begin
      kind = 1'b1;
      lg = (cmd.emit_index >= 5'd13);
    end
    base = lg ? 3'd3 : 3'd0;
    sa = sn[base]; ca = cs[base];
    sh = sn[base + 3'd1]; ch = cs[base + 3'd1];
    sd = sn[base + 3'd2]; cd = cs[base + 3'd2];
    unique case (cmd.emit_index)
      5'd0, 5'd3: begin
        p1a = 32'(sd) * 32'(ca); k1 = $signed({1'b0, shank});
        p2a = 32'(sh) * 32'(ca); k2 = $signed({1'b0, thigh});
        off = 64'($signed({1'b0, fore})) <<< 28;
      end
      5'd1, 5'd4: begin
        p1a = 32'(sa) * 32'sd16384; k1 = $signed({1'b0, reach});
        off = lg ? -(64'($signed({1'b0, side})) <<< 28)
                 : 64'($signed({1'b0, side})) <<< 28;
      end
      5'd2, 5'd5: begin
        p1a = -(32'(cd) * 32'(ca)); k1 = $signed({1'b0, shank});
        p2a = -(32'(ca) * 32'(ch)); k2 = $signed({1'b0, thigh});
        off = -(64'($signed({1'b0, down})) <<< 28);
      end
      5'd6, 5'd13: begin
        row = base; col = {lg, 2'd0};
        p1a = -(32'(sd) * 32'(sa)); k1 = $signed({1'b0, shank});
        p2a = -(32'(sa) * 32'(sh)); k2 = $signed({1'b0, thigh});
      end
      5'd7, 5'd14: begin
        row = base + 3'd1; col = {lg, 2'd0};
        p1a = 32'(ca) * 32'sd16384; k1 = $signed({1'b0, reach});
      end
      5'd8, 5'd15: begin
        row = base + 3'd2; col = {lg, 2'd0};
        p1a = 32'(sa) * 32'(cd); k1 = $signed({1'b0, shank});
        p2a = 32'(sa) * 32'(ch); k2 = $signed({1'b0, thigh});
      end
      5'd9, 5'd16: begin
        row = base; col = {lg, 2'd1};
        p1a = 32'(cd) * 32'(ca); k1 = $signed({1'b0, shank});
        p2a = 32'(ca) * 32'(ch); k2 = $signed({1'b0, thigh});
      end
      5'd10, 5'd17: begin
        row = base + 3'd2; col = {lg, 2'd1};
        p1a = 32'(sd) * 32'(ca); k1 = $signed({1'b0, shank});
        p2a = 32'(sh) * 32'(ca); k2 = $signed({1'b0, thigh});
      end
      5'd11, 5'd18: begin
        row = base; col = {lg, 2'd2};
        p1a = -(32'(cd) * 32'(ca)); k1 = $signed({1'b0, shank});
      end
      5'd12, 5'd19: begin
        row = base + 3'd2; col = {lg, 2'd2};
        p1a = -(32'(sd) * 32'(ca)); k1 = $signed({1'b0, shank});
      end
      default: ;
    endcase
    p1b = p1a;
    p2b = p2a;
    m1 = p1b;
    m2 = p2b;
  end

  // Second stage: registered trig products times lengths, then round.
  logic signed [31:0] m1_q, m2_q;
  logic signed [14:0] k1_q, k2_q;
  logic signed [63:0] off_q, rnd;
  logic [2:0] row_q, col_q;
  logic kind_q, ld_q;
  always_ff @(posedge clk) begin
    if (rst) ld_q <= 1'b0;
    else ld_q <= cmd.emit_load;
    m1_q <= m1; m2_q <= m2; k1_q <= k1; k2_q <= k2; off_q <= off;
    row_q <= row; col_q <= col; kind_q <= kind;
  end

  always_comb begin
    acc = 64'(m1_q) * 64'(k1_q) + 64'(m2_q) * 64'(k2_q) + off_q;
    rnd = (acc + (64'sd1 <<< 27)) >>> 28;
  end

  always_ff @(posedge clk) begin
    if (ld_q) begin
      r_row <= row_q;
      r_col <= col_q;
      r_kind <= kind_q;
      r_value <= (rnd > 64'sd32767) ? 16'sh7fff :
                 ((rnd < -64'sd32768) ? 16'sh8000 : rnd[15:0]);
    end
  end
endmodule

[hdl/leg_forward_kinematics_jacobian_unit.sv]
// Flow: an accepted transaction first drives six sine/cosine runs on the shared
// 17-step CORDIC, then each result passes the product pipeline. One result is in
// the pipeline at a time, and a new transaction is not taken until the last
// result has left the output register.
// Reset is synchronous and active high: registers return to their defaults,
// latched angles clear and the latch is armed.
module leg_forward_kinematics_jacobian_unit import lfkj_pkg::*; #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [ANGLE_WIDTH-1:0] left_hip_flex_angle,
  input  logic signed [ANGLE_WIDTH-1:0] left_knee_angle,
  input  logic signed [ANGLE_WIDTH-1:0] left_hip_abduct_angle,
  input  logic signed [ANGLE_WIDTH-1:0] right_hip_flex_angle,
  input  logic signed [ANGLE_WIDTH-1:0] right_knee_angle,
  input  logic signed [ANGLE_WIDTH-1:0] right_hip_abduct_angle,
  input  logic rearm,
  output logic out_valid,
  input  logic out_stall,
  output logic result_kind,
  output logic [2:0] row_index,
  output logic [2:0] column_index,
  output logic signed [15:0] result_value,
  output logic last,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [13:0] thigh, shank, reach, fore, side, down;
  logic armed, busy, accept;
  lfkj_cmd_t cmd;
  lfkj_status_t status;
  logic signed [ANGLE_WIDTH-1:0] ang_in [6];
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      thigh <= 14'd6554; shank <= 14'd6717; reach <= 14'd13271;
      fore <= 14'd229; side <= 14'd2621; down <= 14'd2359;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_THIGH: thigh <= pwdata[13:0];
        REG_SHANK: shank <= pwdata[13:0];
        REG_REACH: reach <= pwdata[13:0];
        REG_FORE: fore <= pwdata[13:0];
        REG_SIDE: side <= pwdata[13:0];
        REG_DOWN: down <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_THIGH: prdata = {18'd0, thigh};
      REG_SHANK: prdata = {18'd0, shank};
      REG_REACH: prdata = {18'd0, reach};
      REG_FORE: prdata = {18'd0, fore};
      REG_SIDE: prdata = {18'd0, side};
      REG_DOWN: prdata = {18'd0, down};
      default: prdata = '0;
    endcase
  end

  // Results go through the product pipeline; credit tracking keeps
  // the output register free before each issue.
  logic [1:0] inflight;
  logic out_free;
  assign out_free = (inflight == 2'd0) && (!out_valid || !out_stall);
  assign in_stall = busy || (inflight != 2'd0) || out_valid;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) armed <= 1'b1;
    else if (accept) armed <= 1'b0;
  end

  assign ang_in[0] = left_hip_flex_angle;
  assign ang_in[1] = left_knee_angle;
  assign ang_in[2] = left_hip_abduct_angle;
  assign ang_in[3] = right_hip_flex_angle;
  assign ang_in[4] = right_knee_angle;
  assign ang_in[5] = right_hip_abduct_angle;

  lfkj_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(accept), .out_free(out_free),
    .status(status), .cmd(cmd), .busy(busy)
  );

  lfkj_datapath #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .latch(accept && (armed || rearm)), .ang_in(ang_in),
    .thigh(thigh), .shank(shank), .reach(reach), .fore(fore), .side(side),
    .down(down), .cmd(cmd), .status(status),
    .r_row(row_index), .r_col(column_index), .r_kind(result_kind),
    .r_value(result_value)
  );

  logic [1:0] pipe;
  logic last_p1, last_p2;
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe <= '0;
      out_valid <= 1'b0;
      last <= 1'b0;
      last_p1 <= 1'b0;
      last_p2 <= 1'b0;
    end else begin
      pipe <= {pipe[0], cmd.emit_load};
      last_p1 <= cmd.emit_load && (cmd.emit_index == 5'(NRES - 1));
      last_p2 <= last_p1;
      if (pipe[1]) begin
        out_valid <= 1'b1;
        last <= last_p2;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end
  assign inflight = {1'b0, pipe[0]} + {1'b0, pipe[1]};
endmodule

[hdl/lfkj_checker.sv]
// Port-level checker for the leg kinematics unit, bound to the top level.
// Depends on the macro header.
`include "leg_forward_kinematics_jacobian_unit_macros.svh"
module lfkj_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic last,
  input logic [2:0] row_index
);
  `LFKJ_ASSERT_NEXT(a_stall_after_accept, in_valid && !in_stall, in_stall)
  `LFKJ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `LFKJ_ASSERT_IMPL(a_row_range, out_valid, row_index <= 3'd5)
  `LFKJ_ASSERT_IMPL(a_no_accept_while_out, out_valid, in_stall)
  `LFKJ_ASSERT_IMPL(a_last_row, out_valid && last, row_index == 3'd5)
endmodule

bind leg_forward_kinematics_jacobian_unit lfkj_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .last(last),
  .row_index(row_index)
);
